// File: rtl/ckb_pkg.sv
package ckb_pkg;

    localparam int SHEET_DIM_W = 11;
    localparam int GRID_W      = 7;
    localparam int FRAME_W     = 12;
    localparam int DEST_W      = 17;
    localparam int PIX_W       = 16;
    localparam int KEY_W       = 16;
    localparam int GRID_CNT_W  = 2 * GRID_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHEET_WIDTH  = 3'd0,
        REG_SHEET_HEIGHT = 3'd1,
        REG_GRID_COLS    = 3'd2,
        REG_GRID_ROWS    = 3'd3,
        REG_FRAME_INDEX  = 3'd4,
        REG_DEST_BASE    = 3'd5,
        REG_SOLID_MODE   = 3'd6,
        REG_KEY          = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_FRAME,
        ST_DIV_CELL,
        ST_DIV_WIDTH,
        ST_DIV_HEIGHT,
        ST_LATCH,
        ST_EMIT
    } ckb_state_t;

    typedef enum logic [1:0] {
        DIV_FRAME,
        DIV_CELL,
        DIV_WIDTH,
        DIV_HEIGHT
    } div_sel_t;

    typedef struct packed {
        logic     hold_pix;
        logic     emit;
        logic     emit_held;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_cell;
        logic     cap_width;
        logic     cap_height;
        logic     load_window;
    } ckb_cmd_t;

    typedef struct packed {
        logic at_origin;
        logic out_free;
        logic div_done;
    } ckb_status_t;

endpackage

// File: rtl/ckb_divider.sv
module ckb_divider #(
    parameter int DVD_W = 12,
    parameter int DVS_W = 14
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W+1:0] diff;
    logic             borrow;

    // one quotient bit per cycle, restoring
    assign diff   = {1'b0, rem_reg, quo_reg[DVD_W-1]} - {2'b00, dvs_reg};
    assign borrow = diff[DVS_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], ~borrow};
            if (!borrow) begin
                rem_reg <= diff[DVS_W-1:0];
            end else begin
                rem_reg <= {rem_reg[DVS_W-2:0], quo_reg[DVD_W-1]};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/ckb_ctrl.sv
module ckb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  ckb_pkg::ckb_status_t status,
    output logic                s_tready,
    output ckb_pkg::ckb_cmd_t   cmd
);

    import ckb_pkg::*;

    ckb_state_t state_reg;
    ckb_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_FRAME;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = status.out_free;
                if (s_tvalid && status.out_free) begin
                    if (status.at_origin) begin
                        cmd.hold_pix  = 1'b1;
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_FRAME;
                        state_next    = ST_DIV_FRAME;
                    end else begin
                        cmd.emit = 1'b1;
                    end
                end
            end
            ST_DIV_FRAME: begin
                if (status.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_CELL;
                    state_next    = ST_DIV_CELL;
                end
            end
            ST_DIV_CELL: begin
                if (status.div_done) begin
                    cmd.cap_cell  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_WIDTH;
                    state_next    = ST_DIV_WIDTH;
                end
            end
            ST_DIV_WIDTH: begin
                if (status.div_done) begin
                    cmd.cap_width = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_HEIGHT;
                    state_next    = ST_DIV_HEIGHT;
                end
            end
            ST_DIV_HEIGHT: begin
                if (status.div_done) begin
                    cmd.cap_height = 1'b1;
                    state_next     = ST_LATCH;
                end
            end
            ST_LATCH: begin
                cmd.load_window = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_held = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ckb_datapath.sv
module ckb_datapath #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int MAX_SHEET_DIM = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ckb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ckb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [ckb_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                m_tready,
    input  ckb_pkg::ckb_cmd_t                   cmd,
    output ckb_pkg::ckb_status_t                status,
    output logic                                m_tvalid,
    output logic [ckb_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    import ckb_pkg::*;

    localparam int CNT_W    = $clog2(MAX_SHEET_DIM);
    localparam int W_W      = $clog2(MAX_SHEET_DIM + 1);
    localparam int DVD_W    = (W_W > FRAME_W) ? W_W : FRAME_W;
    localparam int DVS_W    = GRID_CNT_W;
    localparam int SCR_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ROW_W    = CNT_W + $clog2(SCREEN_WIDTH + 1);
    localparam int BASE_W   = (ROW_W > DEST_W) ? ROW_W : DEST_W;
    localparam int SCR_W    = $clog2(SCR_SIZE + 1);
    localparam int SUM_W    = ((BASE_W > SCR_W) ? BASE_W : SCR_W) + 1;

    // configuration registers
    logic [SHEET_DIM_W-1:0] sheet_width_reg;
    logic [SHEET_DIM_W-1:0] sheet_height_reg;
    logic [GRID_W-1:0]      grid_cols_reg;
    logic [GRID_W-1:0]      grid_rows_reg;
    logic [FRAME_W-1:0]     frame_index_reg;
    logic [DEST_W-1:0]      dest_base_reg;
    logic                   solid_mode_reg;
    logic [KEY_W-1:0]       key_reg;

    // sheet position and latched frame window
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  top_reg;
    logic [W_W-1:0]    width_reg;
    logic [W_W-1:0]    height_reg;
    logic [DEST_W-1:0] dest_row_start_reg;
    logic [GRID_W-1:0] cell_col_reg;
    logic [GRID_W-1:0] cell_row_reg;
    logic [PIX_W-1:0]  pix_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              out_we_reg;
    logic [DEST_W-1:0] out_addr_reg;
    logic [PIX_W-1:0]  out_pix_reg;
    logic              out_done_reg;

    logic [W_W-1:0]        w_eff;
    logic [W_W-1:0]        h_eff;
    logic [GRID_W-1:0]     cols_eff;
    logic [GRID_W-1:0]     rows_eff;
    logic [GRID_CNT_W-1:0] frame_count;

    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [DVS_W-1:0] div_rem;

    logic [PIX_W-1:0] pix;
    logic [CNT_W-1:0] col_off;
    logic [CNT_W-1:0] row_off;
    logic             in_window;
    logic [SUM_W-1:0] addr_sum;
    logic             wr_en;
    logic             col_wrap;
    logic             row_wrap;
    logic             sheet_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sheet_width_reg  <= SHEET_DIM_W'(1);
            sheet_height_reg <= SHEET_DIM_W'(1);
            grid_cols_reg    <= GRID_W'(1);
            grid_rows_reg    <= GRID_W'(1);
            frame_index_reg  <= '0;
            dest_base_reg    <= '0;
            solid_mode_reg   <= 1'b0;
            key_reg          <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_SHEET_WIDTH:  sheet_width_reg  <= cfg_wdata[SHEET_DIM_W-1:0];
                REG_SHEET_HEIGHT: sheet_height_reg <= cfg_wdata[SHEET_DIM_W-1:0];
                REG_GRID_COLS:    grid_cols_reg    <= cfg_wdata[GRID_W-1:0];
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_wdata[GRID_W-1:0];
                REG_FRAME_INDEX:  frame_index_reg  <= cfg_wdata[FRAME_W-1:0];
                REG_DEST_BASE:    dest_base_reg    <= cfg_wdata[DEST_W-1:0];
                REG_SOLID_MODE:   solid_mode_reg   <= cfg_wdata[0];
                REG_KEY:          key_reg          <= cfg_wdata[KEY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero reads as one, oversize sheet clamps to the maximum
    always_comb begin
        if (sheet_width_reg == '0) begin
            w_eff = W_W'(1);
        end else if (32'(sheet_width_reg) > 32'(MAX_SHEET_DIM)) begin
            w_eff = W_W'(MAX_SHEET_DIM);
        end else begin
            w_eff = W_W'(sheet_width_reg);
        end
        if (sheet_height_reg == '0) begin
            h_eff = W_W'(1);
        end else if (32'(sheet_height_reg) > 32'(MAX_SHEET_DIM)) begin
            h_eff = W_W'(MAX_SHEET_DIM);
        end else begin
            h_eff = W_W'(sheet_height_reg);
        end
        cols_eff    = (grid_cols_reg == '0) ? GRID_W'(1) : grid_cols_reg;
        rows_eff    = (grid_rows_reg == '0) ? GRID_W'(1) : grid_rows_reg;
        frame_count = GRID_CNT_W'(cols_eff) * GRID_CNT_W'(rows_eff);
    end

    always_comb begin
        case (cmd.div_sel)
            DIV_FRAME: begin
                div_dvd = DVD_W'(frame_index_reg);
                div_dvs = DVS_W'(frame_count);
            end
            DIV_CELL: begin
                div_dvd = DVD_W'(div_rem[FRAME_W-1:0]);
                div_dvs = DVS_W'(cols_eff);
            end
            DIV_WIDTH: begin
                div_dvd = DVD_W'(w_eff);
                div_dvs = DVS_W'(cols_eff);
            end
            DIV_HEIGHT: begin
                div_dvd = DVD_W'(h_eff);
                div_dvs = DVS_W'(rows_eff);
            end
            default: begin
                div_dvd = '0;
                div_dvs = DVS_W'(1);
            end
        endcase
    end

    assign div_start = cmd.div_start;

    ckb_divider #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (cmd.hold_pix) begin
            pix_reg <= s_tdata[PIX_W-1:0];
        end
        if (cmd.cap_cell) begin
            cell_col_reg <= div_rem[GRID_W-1:0];
            cell_row_reg <= div_quo[GRID_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg           <= '0;
            top_reg            <= '0;
            width_reg          <= '0;
            height_reg         <= '0;
            dest_row_start_reg <= '0;
        end else begin
            if (cmd.cap_width) begin
                width_reg <= div_quo[W_W-1:0];
            end
            if (cmd.cap_height) begin
                height_reg <= div_quo[W_W-1:0];
            end
            if (cmd.load_window) begin
                left_reg           <= CNT_W'(width_reg * W_W'(cell_col_reg));
                top_reg            <= CNT_W'(height_reg * W_W'(cell_row_reg));
                dest_row_start_reg <= dest_base_reg;
            end
        end
    end

    // per pixel: window test, address, key test, raster advance
    always_comb begin
        pix       = cmd.emit_held ? pix_reg : s_tdata[PIX_W-1:0];
        col_off   = col_reg - left_reg;
        row_off   = row_reg - top_reg;
        in_window = (col_reg >= left_reg) && (W_W'(col_off) < width_reg) &&
                    (row_reg >= top_reg) && (W_W'(row_off) < height_reg);
        addr_sum  = SUM_W'(dest_row_start_reg)
                  + SUM_W'(row_off) * SUM_W'(SCREEN_WIDTH)
                  + SUM_W'(col_off);
        wr_en     = in_window && (solid_mode_reg || (pix != key_reg)) &&
                    (addr_sum < SUM_W'(SCR_SIZE));

        col_wrap   = (32'(col_reg) + 32'd1) >= 32'(w_eff);
        row_wrap   = (32'(row_reg) + 32'd1) >= 32'(h_eff);
        sheet_done = col_wrap && row_wrap;
        col_next   = col_reg;
        row_next   = row_reg;
        if (cmd.emit) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end

        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_we_reg   <= wr_en;
            out_addr_reg <= wr_en ? addr_sum[DEST_W-1:0] : '0;
            out_pix_reg  <= wr_en ? pix : '0;
            out_done_reg <= sheet_done;
        end
    end

    assign status.at_origin = (col_reg == '0) && (row_reg == '0);
    assign status.out_free  = !out_valid_reg || m_tready;
    assign status.div_done  = div_done;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_pix_reg, out_addr_reg, out_we_reg});
    assign m_tlast  = out_done_reg;

endmodule

// File: rtl/color_keyed_sprite_frame_blit_top.sv
// Sprite-sheet frame blitter. The sheet streams in on s_ as one 16-bit pixel per request in
// raster order; every request gives exactly one framebuffer write request on m_, with
// write_enable low for pixels outside the selected frame, transparent in color-key mode, or
// at or beyond SCREEN_WIDTH*SCREEN_HEIGHT, and tlast high on the last pixel of the sheet.
// Pixels are taken one per cycle while m_ accepts them. The first pixel of each sheet holds
// the input while the frame window is worked out by one shared divider at one quotient bit
// per cycle: four divisions of max(12, clog2(MAX_SHEET_DIM+1)) bits (frame, cell, width,
// height), then the window latch, then the emit. Window, frame and destination are taken at
// that first pixel; sheet size, solid mode and key act at once. Write registers only while
// no request is in flight.
module color_keyed_sprite_frame_blit_top #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int MAX_SHEET_DIM = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ckb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ckb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sheet_pixel
    input  logic [ckb_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // write_enable, write_address, write_pixel
    output logic [ckb_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);

    import ckb_pkg::*;

    ckb_cmd_t    cmd;
    ckb_status_t status;

    ckb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    ckb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_SHEET_DIM (MAX_SHEET_DIM)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
